// ===== design/elt_pkg.sv =====
// ----------------------------------------------------------------------------
// elt_pkg
// Shared types, character codes and event codes of the entity lump tokenizer.
// ----------------------------------------------------------------------------
package elt_pkg;

  localparam int LINE_WIDTH   = 20;
  localparam int COLUMN_WIDTH = 16;

  localparam logic [LINE_WIDTH-1:0]   LINE_ONE   = LINE_WIDTH'(1);
  localparam logic [LINE_WIDTH-1:0]   LINE_MAX   = '1;
  localparam logic [COLUMN_WIDTH-1:0] COLUMN_ONE = COLUMN_WIDTH'(1);
  localparam logic [COLUMN_WIDTH-1:0] COLUMN_MAX = '1;

  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_OPEN    = 4'd1,
    EV_CLOSE   = 4'd2,
    EV_KEYCHAR = 4'd3,
    EV_KEYEND  = 4'd4,
    EV_VALCHAR = 4'd5,
    EV_VALEND  = 4'd6,
    EV_ERROR   = 4'd7,
    EV_END     = 4'd8,
    EV_HALTED  = 4'd9
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE              = 3'd0,
    ERR_WANT_BRACE        = 3'd1,
    ERR_WANT_KEY_QUOTE    = 3'd2,
    ERR_WANT_VALUE_QUOTE  = 3'd3,
    ERR_WANT_KEY_OR_CLOSE = 3'd4,
    ERR_EARLY_END         = 3'd5
  } error_t;

  typedef struct packed {
    event_t                  ev;
    logic [7:0]              chr;
    error_t                  err;
    logic [LINE_WIDTH-1:0]   line;
    logic [COLUMN_WIDTH-1:0] column;
  } result_t;

endpackage

// ===== design/entity_lump_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// entity_lump_tokenizer_core
// Byte-serial tokenizer for map entity text, one event per input byte.
// ----------------------------------------------------------------------------
// Input channel: data_valid, data_stall, data_byte and restart. A byte is
// taken at a clock edge with data_valid high and data_stall low; restart on
// a byte clears the parser and the line and column counters first.
// Output channel: result_valid, result_stall and the event fields. A word
// is delivered at an edge with result_valid high and result_stall low.
// Each byte passes an input register, the step logic and a result register:
// its word is loaded into the result register when the input register
// advances and can then be taken; one byte per cycle is sustained while the
// receiver does not stall.
// While the receiver stalls the result register holds its word; the input
// register still takes one more byte, then data_stall rises until the
// result is taken.
// Reset (rst, synchronous) empties both registers, puts the parser between
// entities, the line counter at one and the column counter at zero.
// After an error or an end of data every byte yields a halted word until a
// byte arrives with restart set.
// ----------------------------------------------------------------------------
module entity_lump_tokenizer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             data_valid,
  output logic                             data_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             restart,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [3:0]                       event_res,
  output logic [7:0]                       char_out,
  output logic [2:0]                       error_code,
  output logic [elt_pkg::LINE_WIDTH-1:0]   line_number,
  output logic [elt_pkg::COLUMN_WIDTH-1:0] column_number
);

  logic             stage_valid;
  logic [7:0]       stage_byte;
  logic             stage_restart;
  logic             advance;
  logic             data_take;
  elt_pkg::result_t step_result;
  elt_pkg::result_t result;

  assign advance    = stage_valid && (!result_valid || !result_stall);
  assign data_stall = stage_valid && !advance;
  assign data_take  = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (data_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
    if (data_take) begin
      stage_byte    <= data_byte;
      stage_restart <= restart;
    end
  end

  elt_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (stage_byte),
    .restart   (stage_restart),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= step_result;
    end
  end

  assign event_res     = result.ev;
  assign char_out      = result.chr;
  assign error_code    = result.err;
  assign line_number   = result.line;
  assign column_number = result.column;

endmodule

// ===== design/elt_step.sv =====
// ----------------------------------------------------------------------------
// elt_step
// Tokenizer state and position counters, with the single-byte step logic.
// The result of the byte on the inputs is produced combinationally; state
// moves on when advance is high.
// ----------------------------------------------------------------------------
module elt_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        data_byte,
  input  logic              restart,
  output elt_pkg::result_t  result
);

  typedef enum logic [2:0] {
    ST_BETWEEN       = 3'd0,
    ST_EXP_KEY       = 3'd1,
    ST_IN_KEY        = 3'd2,
    ST_EXP_VAL       = 3'd3,
    ST_IN_VAL        = 3'd4,
    ST_EXP_KEY_CLOSE = 3'd5,
    ST_HALTED        = 3'd6
  } state_t;

  state_t                           parse_state;
  state_t                           parse_state_next;
  logic [elt_pkg::LINE_WIDTH-1:0]   line_count;
  logic [elt_pkg::LINE_WIDTH-1:0]   line_count_next;
  logic [elt_pkg::COLUMN_WIDTH-1:0] column_count;
  logic [elt_pkg::COLUMN_WIDTH-1:0] column_count_next;

  state_t                           base_state;
  logic [elt_pkg::LINE_WIDTH-1:0]   base_line;
  logic [elt_pkg::COLUMN_WIDTH-1:0] base_column;
  logic                             is_blank;
  elt_pkg::event_t                  ev;
  elt_pkg::error_t                  err;
  logic [7:0]                       chr;

  assign is_blank = (data_byte == elt_pkg::CH_SPACE) ||
                    (data_byte inside {[elt_pkg::CH_TAB:elt_pkg::CH_CR]});

  always_comb begin
    base_state  = parse_state;
    base_line   = line_count;
    base_column = column_count;
    if (restart) begin
      base_state  = ST_BETWEEN;
      base_line   = elt_pkg::LINE_ONE;
      base_column = '0;
    end

    parse_state_next  = base_state;
    line_count_next   = base_line;
    column_count_next = base_column;
    ev  = elt_pkg::EV_NONE;
    err = elt_pkg::ERR_NONE;
    chr = '0;

    case (base_state)
      ST_BETWEEN, ST_EXP_KEY, ST_IN_KEY, ST_EXP_VAL, ST_IN_VAL,
      ST_EXP_KEY_CLOSE: begin
        if (data_byte == elt_pkg::CH_NEWLINE) begin
          if (base_line != elt_pkg::LINE_MAX) begin
            line_count_next = base_line + elt_pkg::LINE_ONE;
          end
          column_count_next = '0;
        end else if (base_column != elt_pkg::COLUMN_MAX) begin
          column_count_next = base_column + elt_pkg::COLUMN_ONE;
        end

        if (data_byte == elt_pkg::CH_NUL) begin
          if (base_state == ST_BETWEEN) begin
            ev = elt_pkg::EV_END;
          end else begin
            ev  = elt_pkg::EV_ERROR;
            err = elt_pkg::ERR_EARLY_END;
          end
          parse_state_next = ST_HALTED;
        end else begin
          case (base_state)
            ST_BETWEEN: begin
              if (data_byte == elt_pkg::CH_LBRACE) begin
                ev = elt_pkg::EV_OPEN;
                parse_state_next = ST_EXP_KEY;
              end else if (!is_blank) begin
                ev  = elt_pkg::EV_ERROR;
                err = elt_pkg::ERR_WANT_BRACE;
              end
            end
            ST_EXP_KEY: begin
              if (data_byte == elt_pkg::CH_QUOTE) begin
                parse_state_next = ST_IN_KEY;
              end else if (!is_blank) begin
                ev  = elt_pkg::EV_ERROR;
                err = elt_pkg::ERR_WANT_KEY_QUOTE;
              end
            end
            ST_IN_KEY: begin
              if (data_byte == elt_pkg::CH_QUOTE) begin
                ev = elt_pkg::EV_KEYEND;
                parse_state_next = ST_EXP_VAL;
              end else begin
                ev  = elt_pkg::EV_KEYCHAR;
                chr = data_byte;
              end
            end
            ST_EXP_VAL: begin
              if (data_byte == elt_pkg::CH_QUOTE) begin
                parse_state_next = ST_IN_VAL;
              end else if (!is_blank) begin
                ev  = elt_pkg::EV_ERROR;
                err = elt_pkg::ERR_WANT_VALUE_QUOTE;
              end
            end
            ST_IN_VAL: begin
              if (data_byte == elt_pkg::CH_QUOTE) begin
                ev = elt_pkg::EV_VALEND;
                parse_state_next = ST_EXP_KEY_CLOSE;
              end else begin
                ev  = elt_pkg::EV_VALCHAR;
                chr = data_byte;
              end
            end
            default: begin
              if (data_byte == elt_pkg::CH_QUOTE) begin
                parse_state_next = ST_IN_KEY;
              end else if (data_byte == elt_pkg::CH_RBRACE) begin
                ev = elt_pkg::EV_CLOSE;
                parse_state_next = ST_BETWEEN;
              end else if (!is_blank) begin
                ev  = elt_pkg::EV_ERROR;
                err = elt_pkg::ERR_WANT_KEY_OR_CLOSE;
              end
            end
          endcase
          if (ev == elt_pkg::EV_ERROR) begin
            chr = data_byte;
            parse_state_next = ST_HALTED;
          end
        end
      end
      default: begin
        // halted, and the unused code behaves the same
        ev = elt_pkg::EV_HALTED;
      end
    endcase
  end

  assign result.ev     = ev;
  assign result.chr    = chr;
  assign result.err    = err;
  assign result.line   = line_count_next;
  assign result.column = column_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state  <= ST_BETWEEN;
      line_count   <= elt_pkg::LINE_ONE;
      column_count <= '0;
    end else if (advance) begin
      parse_state  <= parse_state_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
    end
  end

  a_halt_after_stop: assert property (@(posedge clk) disable iff (rst)
    advance && (ev == elt_pkg::EV_ERROR || ev == elt_pkg::EV_END)
    |=> parse_state == ST_HALTED)
    else $error("tokenizer did not halt after error or end");

  a_frozen_when_halted: assert property (@(posedge clk) disable iff (rst)
    advance && !restart && parse_state == ST_HALTED
    |=> $stable(line_count) && $stable(column_count) && parse_state == ST_HALTED)
    else $error("position moved while halted");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    advance |=> line_count != '0)
    else $error("line counter reached zero");

  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    advance && ev == elt_pkg::EV_ERROR |-> err != elt_pkg::ERR_NONE)
    else $error("error event without a code");

endmodule

// ===== verif/tb_entity_lump_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// tb_entity_lump_tokenizer_core
// Self-checking bench for the entity text tokenizer. A directed table covers
// every event and error code, then random entities with noise, early ends and
// restarts run under three stall patterns. Every event word is compared with
// the table's expected word or with an in-bench tokenizer model.
// ----------------------------------------------------------------------------
module tb_entity_lump_tokenizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PS_BETWEEN,
    PS_EXP_KEY,
    PS_IN_KEY,
    PS_EXP_VAL,
    PS_IN_VAL,
    PS_EXP_KEY_CLOSE,
    PS_HALTED
  } parse_state_t;

  typedef struct {
    logic [7:0]       b;
    logic             rs;
    logic             typed;
    elt_pkg::result_t want;
  } stim_row_t;

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             data_valid   = 1'b0;
  logic                             data_stall;
  logic [7:0]                       data_byte    = 8'h00;
  logic                             restart      = 1'b0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic [3:0]                       event_res;
  logic [7:0]                       char_out;
  logic [2:0]                       error_code;
  logic [elt_pkg::LINE_WIDTH-1:0]   line_number;
  logic [elt_pkg::COLUMN_WIDTH-1:0] column_number;

  parse_state_t                     tok_state = PS_BETWEEN;
  logic [elt_pkg::LINE_WIDTH-1:0]   tok_line  = elt_pkg::LINE_ONE;
  logic [elt_pkg::COLUMN_WIDTH-1:0] tok_col   = '0;

  elt_pkg::result_t expected_events [$];
  stim_row_t        directed_rows [28];
  int               send_idle_pct = 36;
  int               recv_idle_pct = 67;
  int               words_in      = 0;
  int               rand_words    = 0;
  int               words_checked = 0;
  int               errors_seen   = 0;
  int               ends_seen     = 0;
  int               mismatches    = 0;

  entity_lump_tokenizer_core dut (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .data_byte     (data_byte),
    .restart       (restart),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .event_res     (event_res),
    .char_out      (char_out),
    .error_code    (error_code),
    .line_number   (line_number),
    .column_number (column_number)
  );

  always #2 clk = ~clk;

  function automatic elt_pkg::result_t tokenize_step(input logic [7:0] b, input logic rs);
    elt_pkg::result_t r;
    logic             blank;
    r = '0;
    blank = (b == elt_pkg::CH_SPACE) || (b >= elt_pkg::CH_TAB && b <= elt_pkg::CH_CR);
    if (rs) begin
      tok_state = PS_BETWEEN;
      tok_line  = elt_pkg::LINE_ONE;
      tok_col   = '0;
    end
    if (tok_state == PS_HALTED) begin
      r.ev = elt_pkg::EV_HALTED;
    end else begin
      if (b == elt_pkg::CH_NEWLINE) begin
        if (tok_line != elt_pkg::LINE_MAX) tok_line++;
        tok_col = '0;
      end else if (tok_col != elt_pkg::COLUMN_MAX) begin
        tok_col++;
      end
      if (b == elt_pkg::CH_NUL) begin
        if (tok_state == PS_BETWEEN) begin
          r.ev = elt_pkg::EV_END;
        end else begin
          r.ev  = elt_pkg::EV_ERROR;
          r.err = elt_pkg::ERR_EARLY_END;
        end
        tok_state = PS_HALTED;
      end else begin
        case (tok_state)
          PS_BETWEEN: begin
            if (b == elt_pkg::CH_LBRACE) begin
              r.ev = elt_pkg::EV_OPEN;
              tok_state = PS_EXP_KEY;
            end else if (!blank) begin
              r.ev  = elt_pkg::EV_ERROR;
              r.err = elt_pkg::ERR_WANT_BRACE;
            end
          end
          PS_EXP_KEY: begin
            if (b == elt_pkg::CH_QUOTE) tok_state = PS_IN_KEY;
            else if (!blank) begin
              r.ev  = elt_pkg::EV_ERROR;
              r.err = elt_pkg::ERR_WANT_KEY_QUOTE;
            end
          end
          PS_IN_KEY: begin
            if (b == elt_pkg::CH_QUOTE) begin
              r.ev = elt_pkg::EV_KEYEND;
              tok_state = PS_EXP_VAL;
            end else begin
              r.ev  = elt_pkg::EV_KEYCHAR;
              r.chr = b;
            end
          end
          PS_EXP_VAL: begin
            if (b == elt_pkg::CH_QUOTE) tok_state = PS_IN_VAL;
            else if (!blank) begin
              r.ev  = elt_pkg::EV_ERROR;
              r.err = elt_pkg::ERR_WANT_VALUE_QUOTE;
            end
          end
          PS_IN_VAL: begin
            if (b == elt_pkg::CH_QUOTE) begin
              r.ev = elt_pkg::EV_VALEND;
              tok_state = PS_EXP_KEY_CLOSE;
            end else begin
              r.ev  = elt_pkg::EV_VALCHAR;
              r.chr = b;
            end
          end
          default: begin
            if (b == elt_pkg::CH_QUOTE) tok_state = PS_IN_KEY;
            else if (b == elt_pkg::CH_RBRACE) begin
              r.ev = elt_pkg::EV_CLOSE;
              tok_state = PS_BETWEEN;
            end else if (!blank) begin
              r.ev  = elt_pkg::EV_ERROR;
              r.err = elt_pkg::ERR_WANT_KEY_OR_CLOSE;
            end
          end
        endcase
        if (r.ev == elt_pkg::EV_ERROR) begin
          r.chr = b;
          tok_state = PS_HALTED;
        end
      end
    end
    r.line   = tok_line;
    r.column = tok_col;
    return r;
  endfunction

  function automatic stim_row_t plain_row(input logic [7:0] b, input logic rs);
    stim_row_t s;
    s.b     = b;
    s.rs    = rs;
    s.typed = 1'b0;
    s.want  = '0;
    return s;
  endfunction

  function automatic stim_row_t known_row(input logic [7:0] b, input logic rs,
                                          input elt_pkg::event_t ev, input logic [7:0] c,
                                          input elt_pkg::error_t e, input int ln,
                                          input int col);
    stim_row_t s;
    s.b           = b;
    s.rs          = rs;
    s.typed       = 1'b1;
    s.want.ev     = ev;
    s.want.chr    = c;
    s.want.err    = e;
    s.want.line   = elt_pkg::LINE_WIDTH'(ln);
    s.want.column = elt_pkg::COLUMN_WIDTH'(col);
    return s;
  endfunction

  task automatic feed_byte(input logic [7:0] b, input logic rs, input logic typed,
                           input elt_pkg::result_t want);
    elt_pkg::result_t pred;
    data_valid <= 1'b1;
    data_byte  <= b;
    restart    <= rs;
    @(posedge clk);
    while (data_stall !== 1'b0) @(posedge clk);
    pred = tokenize_step(b, rs);
    expected_events.insert(expected_events.size(), typed ? want : pred);
    words_in++;
    while ($urandom_range(99) < send_idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // occasional corrupt byte and stray restart; restart always follows a halt
  task automatic send_char(input logic [7:0] b);
    logic [7:0] c;
    c = ($urandom_range(149) == 0) ? 8'($urandom) : b;
    feed_byte(c, (tok_state == PS_HALTED) || ($urandom_range(199) == 0), 1'b0, '0);
    rand_words++;
  endtask

  task automatic send_blanks();
    int n;
    n = $urandom_range(2);
    repeat (n)
      case ($urandom_range(5))
        0: send_char(elt_pkg::CH_SPACE);
        1: send_char(elt_pkg::CH_TAB);
        2: send_char(elt_pkg::CH_NEWLINE);
        3: send_char(elt_pkg::CH_CR);
        4: send_char(8'h0B);
        default: send_char(8'h0C);
      endcase
  endtask

  task automatic send_string();
    logic [7:0] c;
    int         n;
    n = $urandom_range(5);
    send_char(elt_pkg::CH_QUOTE);
    repeat (n) begin
      c = 8'($urandom_range(255, 1));
      if (c == elt_pkg::CH_QUOTE) c = 8'h27;
      send_char(c);
    end
    send_char(elt_pkg::CH_QUOTE);
  endtask

  task automatic send_entity();
    send_char(elt_pkg::CH_LBRACE);
    send_blanks();
    repeat ($urandom_range(3)) begin
      send_string();
      send_blanks();
      send_string();
      send_blanks();
    end
    send_char(elt_pkg::CH_RBRACE);
    send_blanks();
  endtask

  task automatic wait_for_results();
    data_valid <= 1'b0;
    do @(posedge clk); while (expected_events.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    elt_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual event %0d", $time,
                   event_res);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", 32'(want.ev), 32'(event_res));
          check_field("char_out", 32'(want.chr), 32'(char_out));
          check_field("error_code", 32'(want.err), 32'(error_code));
          check_field("line_number", 32'(want.line), 32'(line_number));
          check_field("column_number", 32'(want.column), 32'(column_number));
          words_checked++;
          if (want.ev == elt_pkg::EV_ERROR) errors_seen++;
          if (want.ev == elt_pkg::EV_END) ends_seen++;
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    int pick;
    directed_rows = '{
      known_row(elt_pkg::CH_LBRACE, 1'b0, elt_pkg::EV_OPEN, 8'h00, elt_pkg::ERR_NONE, 1, 1),
      plain_row(elt_pkg::CH_QUOTE, 1'b0),
      known_row(8'hFF, 1'b0, elt_pkg::EV_KEYCHAR, 8'hFF, elt_pkg::ERR_NONE, 1, 3),
      plain_row(elt_pkg::CH_QUOTE, 1'b0),
      plain_row(elt_pkg::CH_TAB, 1'b0),
      plain_row(elt_pkg::CH_QUOTE, 1'b0),
      plain_row(elt_pkg::CH_NEWLINE, 1'b0),
      plain_row(8'h80, 1'b0),
      plain_row(elt_pkg::CH_QUOTE, 1'b0),
      plain_row(elt_pkg::CH_RBRACE, 1'b0),
      known_row(elt_pkg::CH_NUL, 1'b0, elt_pkg::EV_END, 8'h00, elt_pkg::ERR_NONE, 2, 4),
      known_row("y", 1'b0, elt_pkg::EV_HALTED, 8'h00, elt_pkg::ERR_NONE, 2, 4),
      known_row(elt_pkg::CH_RBRACE, 1'b1, elt_pkg::EV_ERROR, elt_pkg::CH_RBRACE,
                elt_pkg::ERR_WANT_BRACE, 1, 1),
      plain_row(elt_pkg::CH_LBRACE, 1'b1),
      known_row("k", 1'b0, elt_pkg::EV_ERROR, "k", elt_pkg::ERR_WANT_KEY_QUOTE, 1, 2),
      plain_row(elt_pkg::CH_LBRACE, 1'b1),
      plain_row(elt_pkg::CH_QUOTE, 1'b0),
      plain_row(elt_pkg::CH_QUOTE, 1'b0),
      known_row("v", 1'b0, elt_pkg::EV_ERROR, "v", elt_pkg::ERR_WANT_VALUE_QUOTE, 1, 4),
      plain_row(elt_pkg::CH_LBRACE, 1'b1),
      plain_row(elt_pkg::CH_SPACE, 1'b0),
      plain_row(elt_pkg::CH_QUOTE, 1'b0),
      plain_row(elt_pkg::CH_QUOTE, 1'b0),
      plain_row(elt_pkg::CH_QUOTE, 1'b0),
      plain_row(elt_pkg::CH_QUOTE, 1'b0),
      known_row("~", 1'b0, elt_pkg::EV_ERROR, "~", elt_pkg::ERR_WANT_KEY_OR_CLOSE, 1, 7),
      plain_row(elt_pkg::CH_LBRACE, 1'b1),
      known_row(elt_pkg::CH_NUL, 1'b0, elt_pkg::EV_ERROR, 8'h00, elt_pkg::ERR_EARLY_END,
                1, 2)
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      feed_byte(directed_rows[i].b, directed_rows[i].rs, directed_rows[i].typed,
                directed_rows[i].want);
    wait_for_results();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 67 : 0;
      recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 36 : 0;
      while (rand_words < (phase + 1) * 200) begin
        pick = $urandom_range(99);
        if (pick < 75) send_entity();
        else if (pick < 83) send_char(elt_pkg::CH_NUL);
        else if (pick < 98) repeat ($urandom_range(4, 1)) send_char(8'($urandom));
        else wait_for_results();
      end
      wait_for_results();
    end

    repeat (20) @(posedge clk);
    $display("%0d bytes sent, %0d event words checked, %0d syntax errors, %0d ends of data",
             words_in, words_checked, errors_seen, ends_seen);
    $display("directed table, then random entities with noise under three stall patterns");
    if (mismatches == 0) $display("tb_entity_lump_tokenizer_core: PASS");
    else $display("tb_entity_lump_tokenizer_core: FAIL");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_entity_lump_tokenizer_core: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/elt_pkg.sv
design/elt_step.sv
design/entity_lump_tokenizer_core.sv
verif/tb_entity_lump_tokenizer_core.sv
